>>> src/dpq_pkg.sv
// shared types, codes and key compare functions for the deadline priority queue
package dpq_pkg;

  // list depth and derived widths
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_REKEY  = 2'd2;

  // result status codes
  localparam logic [2:0] RES_INSERTED = 3'd0;
  localparam logic [2:0] RES_POPPED   = 3'd1;
  localparam logic [2:0] RES_REKEYED  = 3'd2;
  localparam logic [2:0] RES_MISS     = 3'd3;
  localparam logic [2:0] RES_FULL     = 3'd4;

  // one list entry
  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  prio;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } entry_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_REMOVE,
    S_SEEK,
    S_PLACE,
    S_POP,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_req;
    logic       cur_clr;
    logic       cur_inc;
    logic       remove;
    logic       place;
    logic       pop_grab;
    logic       set_res;
    logic [2:0] res_code;
    logic       load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] req;
    logic       empty;
    logic       full;
    logic       at_end;
    logic       tag_hit;
    logic       place_hit;
    logic       out_free;
  } sts_t;

  // true if a is served strictly before b
  function automatic logic outranks(entry_t a, entry_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = a.prio > b.prio;
    end else if (a.year != b.year) begin
      r = a.year < b.year;
    end else if (a.month != b.month) begin
      r = a.month < b.month;
    end else begin
      r = a.day < b.day;
    end
    return r;
  endfunction

  // true if both entries carry the same service key
  function automatic logic keys_equal(entry_t a, entry_t b);
    return (a.prio == b.prio) && (a.year == b.year) &&
           (a.month == b.month) && (a.day == b.day);
  endfunction

endpackage

>>> src/dpq_datapath.sv
// datapath: entry registers, cursor, compare logic and result register
module dpq_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      in_req_type,
  input  logic [15:0]     in_tag,
  input  logic [7:0]      in_prio,
  input  logic [13:0]     in_due_year,
  input  logic [3:0]      in_due_month,
  input  logic [4:0]      in_due_day,
  input  dpq_pkg::cmd_t   cmd,
  output dpq_pkg::sts_t   sts,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_status,
  output logic [15:0]     out_tag,
  output logic [7:0]      out_prio,
  output logic [13:0]     out_year,
  output logic [3:0]      out_month,
  output logic [4:0]      out_day,
  output logic            out_next_valid,
  output logic [15:0]     out_next_tag,
  output logic [4:0]      out_occupancy
);
  import dpq_pkg::*;

  logic [1:0]       req_r;
  entry_t           new_r;
  entry_t           pop_r;
  logic [2:0]       res_r;
  entry_t           ent_r [ENTRIES];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] cur_r;
  logic [CNT_W-1:0] key_r;
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  entry_t           out_e_r;
  logic             out_next_valid_r;
  logic [15:0]      out_next_tag_r;
  logic [4:0]       out_occ_r;

  entry_t           cur_e;
  logic [CNT_W+4:0] cnt_ext;

  // entry under the cursor and compares against the held request
  assign cur_e   = ent_r[cur_r[IDX_W-1:0]];
  assign cnt_ext = (CNT_W + 5)'(count_r);

  always_comb begin
    sts.req       = req_r;
    sts.empty     = (count_r == '0);
    sts.full      = (count_r == CNT_W'(ENTRIES));
    sts.at_end    = (cur_r == count_r);
    sts.tag_hit   = (cur_e.tag == new_r.tag);
    // a rekeyed entry stays behind equal keys that stood ahead of it
    sts.place_hit = outranks(new_r, cur_e) ||
                    ((req_r == REQ_REKEY) && keys_equal(new_r, cur_e) && (cur_r >= key_r));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // request capture, popped entry, status code
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req_type;
      new_r <= '{tag: in_tag, prio: in_prio, year: in_due_year,
                 month: in_due_month, day: in_due_day};
      pop_r <= '0;
    end else if (cmd.pop_grab) begin
      pop_r <= ent_r[0];
    end
    if (cmd.set_res) begin
      res_r <= cmd.res_code;
    end
    if (cmd.remove) begin
      key_r <= cur_r;
    end
  end

  // entry slots: close the gap at the cursor or open one for the new entry
  for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
    entry_t nx_e;
    entry_t pv_e;
    if (g == ENTRIES - 1) begin : g_last
      assign nx_e = ent_r[g];
    end else begin : g_mid
      assign nx_e = ent_r[g+1];
    end
    if (g == 0) begin : g_first
      assign pv_e = new_r;
    end else begin : g_rest
      assign pv_e = ent_r[g-1];
    end
    always_ff @(posedge clk) begin
      if (cmd.remove && (CNT_W'(g) >= cur_r)) begin
        ent_r[g] <= nx_e;
      end else if (cmd.place && (CNT_W'(g) == cur_r)) begin
        ent_r[g] <= new_r;
      end else if (cmd.place && (CNT_W'(g) > cur_r)) begin
        ent_r[g] <= pv_e;
      end
    end
  end

  // fill count and walk cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cur_r   <= '0;
    end else begin
      if (cmd.remove) begin
        count_r <= count_r - 1'b1;
      end else if (cmd.place) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.cur_clr) begin
        cur_r <= '0;
      end else if (cmd.cur_inc) begin
        cur_r <= cur_r + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r     <= res_r;
      out_e_r          <= pop_r;
      out_next_valid_r <= (count_r != '0);
      out_next_tag_r   <= (count_r != '0) ? ent_r[0].tag : 16'd0;
      out_occ_r        <= cnt_ext[4:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_tag        = out_e_r.tag;
  assign out_prio       = out_e_r.prio;
  assign out_year       = out_e_r.year;
  assign out_month      = out_e_r.month;
  assign out_day        = out_e_r.day;
  assign out_next_valid = out_next_valid_r;
  assign out_next_tag   = out_next_tag_r;
  assign out_occupancy  = out_occ_r;

endmodule

>>> src/dpq_ctrl.sv
// controller: sequences insert, pop and rekey walks over the entry list
module dpq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dpq_pkg::sts_t sts,
  output dpq_pkg::cmd_t cmd
);
  import dpq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.req)
          REQ_INSERT: state_nxt = sts.full ? S_DONE : S_SEEK;
          REQ_POP:    state_nxt = sts.empty ? S_DONE : S_POP;
          REQ_REKEY:  state_nxt = S_FIND;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_FIND: begin
        if (sts.at_end) begin
          state_nxt = S_DONE;
        end else if (sts.tag_hit) begin
          state_nxt = S_REMOVE;
        end
      end
      S_REMOVE: state_nxt = S_SEEK;
      S_SEEK: begin
        if (sts.at_end || sts.place_hit) state_nxt = S_PLACE;
      end
      S_PLACE: state_nxt = S_DONE;
      S_POP:   state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          cmd.cur_clr  = 1'b1;
        end
      end
      S_DECODE: begin
        case (sts.req)
          REQ_INSERT: begin
            if (sts.full) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = RES_FULL;
            end
          end
          REQ_POP: begin
            if (sts.empty) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = RES_MISS;
            end
          end
          REQ_REKEY: begin
            cmd.set_res = 1'b0;
          end
          default: begin
            cmd.set_res  = 1'b1;
            cmd.res_code = RES_MISS;
          end
        endcase
      end
      S_FIND: begin
        if (sts.at_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = RES_MISS;
        end else if (!sts.tag_hit) begin
          cmd.cur_inc = 1'b1;
        end
      end
      S_REMOVE: begin
        cmd.remove  = 1'b1;
        cmd.cur_clr = 1'b1;
      end
      S_SEEK: begin
        if (!(sts.at_end || sts.place_hit)) cmd.cur_inc = 1'b1;
      end
      S_PLACE: begin
        cmd.place    = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = (sts.req == REQ_REKEY) ? RES_REKEYED : RES_INSERTED;
      end
      S_POP: begin
        cmd.pop_grab = 1'b1;
        cmd.remove   = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = RES_POPPED;
      end
      S_DONE: begin
        if (sts.out_free) cmd.load_out = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> src/deadline_priority_queue_top.sv
// top level of the deadline priority queue: controller plus datapath
//
// Request beats arrive on in_valid/in_ready: insert an entry, pop the head,
// or rekey the entry with a given tag. Every request beat yields exactly one
// result beat on out_valid/out_ready with a status, the popped entry (zero
// unless popped), the new head tag and the occupancy.
// The list is held sorted: highest priority first, then earliest deadline;
// an insert goes behind entries with an equal key, a rekeyed entry keeps its
// place among equal keys. Inserts and rekeys walk the list with one cursor
// through a single compare unit, one entry per cycle.
// A new request is taken once the previous one has been moved into the
// result register; the result register lets one finished result wait while
// the next request is accepted. If the receiver stalls with a result still
// waiting, the controller holds the finished request until it can be stored.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; no clearing pass is needed.
module deadline_priority_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_tag,
  input  logic [7:0]  in_prio,
  input  logic [13:0] in_due_year,
  input  logic [3:0]  in_due_month,
  input  logic [4:0]  in_due_day,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_tag,
  output logic [7:0]  out_prio,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic        out_next_valid,
  output logic [15:0] out_next_tag,
  output logic [4:0]  out_occupancy
);
  import dpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  dpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // list storage and compare
  dpq_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req_type),
    .in_tag         (in_tag),
    .in_prio        (in_prio),
    .in_due_year    (in_due_year),
    .in_due_month   (in_due_month),
    .in_due_day     (in_due_day),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_tag        (out_tag),
    .out_prio       (out_prio),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_next_valid (out_next_valid),
    .out_next_tag   (out_next_tag),
    .out_occupancy  (out_occupancy)
  );

endmodule

>>> verif/tb_deadline_priority_queue_top.sv
// testbench for deadline_priority_queue_top: directed corners and random traffic against a list model
module tb_deadline_priority_queue_top;
  import dpq_pkg::*;

  // request code the block answers with a miss
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 800_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_SHOWN    = 10;

  // one result beat as seen on the output ports
  typedef struct packed {
    logic [2:0]  status;
    entry_t      popped;
    logic        next_valid;
    logic [15:0] next_tag;
    logic [4:0]  occupancy;
  } qresult_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type    = '0;
  logic [15:0] in_tag         = '0;
  logic [7:0]  in_prio        = '0;
  logic [13:0] in_due_year    = '0;
  logic [3:0]  in_due_month   = '0;
  logic [4:0]  in_due_day     = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_tag;
  logic [7:0]  out_prio;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic        out_next_valid;
  logic [15:0] out_next_tag;
  logic [4:0]  out_occupancy;

  deadline_priority_queue_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_tag         (in_tag),
    .in_prio        (in_prio),
    .in_due_year    (in_due_year),
    .in_due_month   (in_due_month),
    .in_due_day     (in_due_day),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_tag        (out_tag),
    .out_prio       (out_prio),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_next_valid (out_next_valid),
    .out_next_tag   (out_next_tag),
    .out_occupancy  (out_occupancy)
  );

  // service list model and bookkeeping
  entry_t   held [ENTRIES];
  int       held_count;
  qresult_t pending_results [$];
  qresult_t seen_result;
  qresult_t wanted_result;
  bit       steady      = 1'b0;
  int       fault_count = 0;
  int       stall_left  = 0;
  int       cycle_count;
  int       n_answered  = 0;
  int       n_inserted  = 0;
  int       n_popped    = 0;
  int       n_rekeyed   = 0;
  int       n_missed    = 0;
  int       n_full      = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_deadline_priority_queue_top: done, errors");
    $finish;
  end

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(12, 40);
  endfunction

  // service order: priority, then year, month, day
  function automatic bit serves_before(entry_t a, entry_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    if (a.year != b.year) return a.year < b.year;
    if (a.month != b.month) return a.month < b.month;
    return a.day < b.day;
  endfunction

  // stable insertion sort over the held entries
  function automatic void reorder_held();
    entry_t cur;
    int     j;
    for (int i = 1; i < held_count; i++) begin
      cur = held[i];
      j = i;
      while (j > 0 && serves_before(cur, held[j-1])) begin
        held[j] = held[j-1];
        j--;
      end
      held[j] = cur;
    end
  endfunction

  // apply one accepted request to the list model, return its result
  function automatic qresult_t apply_request(logic [1:0] req, entry_t e);
    qresult_t r;
    int       hit;
    r = '0;
    r.status = RES_MISS;
    case (req)
      REQ_INSERT: begin
        if (held_count >= ENTRIES) begin
          r.status = RES_FULL;
        end else begin
          held[held_count] = e;
          held_count++;
          reorder_held();
          r.status = RES_INSERTED;
        end
      end
      REQ_POP: begin
        if (held_count > 0) begin
          r.popped = held[0];
          for (int i = 1; i < held_count; i++) held[i-1] = held[i];
          held_count--;
          r.status = RES_POPPED;
        end
      end
      REQ_REKEY: begin
        hit = -1;
        for (int i = 0; i < held_count; i++) begin
          if (hit < 0 && held[i].tag == e.tag) hit = i;
        end
        if (hit >= 0) begin
          held[hit].prio  = e.prio;
          held[hit].year  = e.year;
          held[hit].month = e.month;
          held[hit].day   = e.day;
          reorder_held();
          r.status = RES_REKEYED;
        end
      end
      default: begin
      end
    endcase
    r.next_valid = (held_count > 0);
    r.next_tag   = (held_count > 0) ? held[0].tag : 16'd0;
    r.occupancy  = 5'(held_count);
    case (r.status)
      RES_INSERTED: n_inserted++;
      RES_POPPED:   n_popped++;
      RES_REKEYED:  n_rekeyed++;
      RES_FULL:     n_full++;
      default:      n_missed++;
    endcase
    return r;
  endfunction

  function automatic entry_t make_entry(logic [15:0] tag, logic [7:0] prio,
                                        logic [13:0] year, logic [3:0] month,
                                        logic [4:0] day);
    entry_t e;
    e.tag   = tag;
    e.prio  = prio;
    e.year  = year;
    e.month = month;
    e.day   = day;
    return e;
  endfunction

  // random entry; crowded keys make many ties and shared tags
  function automatic entry_t random_entry(bit crowded);
    entry_t e;
    if (crowded) begin
      e.tag   = 16'($urandom_range(0, 15));
      e.prio  = 8'($urandom_range(0, 2));
      e.year  = 14'($urandom_range(2024, 2025));
      e.month = 4'($urandom_range(1, 2));
      e.day   = 5'($urandom_range(1, 3));
    end else begin
      e.tag   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
      case ($urandom_range(0, 3))
        0:       e.prio = 8'd0;
        1:       e.prio = 8'd255;
        2:       e.prio = 8'($urandom_range(0, 3));
        default: e.prio = 8'($urandom);
      endcase
      e.year  = ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'($urandom_range(0, 9999));
      e.month = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
      e.day   = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 31));
    end
    return e;
  endfunction

  // send one request beat, record its expected result, then idle a while
  task automatic send_request(logic [1:0] req, entry_t e);
    int gap;
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_tag       <= e.tag;
    in_prio      <= e.prio;
    in_due_year  <= e.year;
    in_due_month <= e.month;
    in_due_day   <= e.day;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), apply_request(req, e));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every expected result has come back
  task automatic settle_results();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // pop, rekey and the unused code on an empty list
  task automatic test_empty_list();
    send_request(REQ_POP, make_entry(16'h0000, 8'd0, 14'd0, 4'd1, 5'd1));
    send_request(REQ_REKEY, make_entry(16'h1234, 8'd7, 14'd2000, 4'd1, 5'd1));
    send_request(REQ_UNUSED, make_entry(16'hFFFF, 8'd255, 14'h3FFF, 4'd15, 5'd31));
  endtask

  // fill to capacity with field extremes, deadline ties and a duplicate tag
  task automatic test_fill_and_order();
    entry_t e;
    send_request(REQ_INSERT, make_entry(16'h0000, 8'd0, 14'd0, 4'd1, 5'd1));
    send_request(REQ_INSERT, make_entry(16'hFFFF, 8'd255, 14'h3FFF, 4'd15, 5'd31));
    send_request(REQ_INSERT, make_entry(16'h00A1, 8'd100, 14'd2030, 4'd6, 5'd15));
    send_request(REQ_INSERT, make_entry(16'h00A2, 8'd100, 14'd2030, 4'd6, 5'd15));
    send_request(REQ_INSERT, make_entry(16'h00A3, 8'd100, 14'd2029, 4'd12, 5'd31));
    send_request(REQ_INSERT, make_entry(16'h00A4, 8'd100, 14'd2030, 4'd5, 5'd31));
    send_request(REQ_INSERT, make_entry(16'h00A5, 8'd100, 14'd2030, 4'd6, 5'd14));
    send_request(REQ_INSERT, make_entry(16'h00A1, 8'd50, 14'd9999, 4'd12, 5'd31));
    send_request(REQ_INSERT, make_entry(16'h5A5A, 8'd255, 14'd0, 4'd0, 5'd0));
    send_request(REQ_INSERT, make_entry(16'hA5A5, 8'd1, 14'd9999, 4'd1, 5'd1));
    for (int i = 0; i < ENTRIES - 10; i++) begin
      e = random_entry(1'b0);
      e.tag = 16'h0100 + 16'(i);
      send_request(REQ_INSERT, e);
    end
    // one more insert on a full list
    send_request(REQ_INSERT, make_entry(16'h7777, 8'd200, 14'd1, 4'd1, 5'd1));
  endtask

  // rekey on a duplicate tag, an unknown tag and onto an existing key
  task automatic test_rekey_cases();
    send_request(REQ_REKEY, make_entry(16'h00A1, 8'd255, 14'd0, 4'd1, 5'd1));
    send_request(REQ_REKEY, make_entry(16'hBEEF, 8'd9, 14'd100, 4'd2, 5'd2));
    send_request(REQ_REKEY, make_entry(16'h00A5, 8'd100, 14'd2030, 4'd6, 5'd15));
  endtask

  task automatic test_pop_head();
    repeat (3) send_request(REQ_POP, random_entry(1'b0));
  endtask

  // random traffic; weights in percent, the rest goes to the unused code
  task automatic run_random(int items, int ins_w, int pop_w, int rekey_w, bit crowded);
    int         counted;
    int         r;
    logic [1:0] req;
    entry_t     e;
    counted = 0;
    while (counted < items) begin
      r = $urandom_range(0, 99);
      if (r < ins_w) req = REQ_INSERT;
      else if (r < ins_w + pop_w) req = REQ_POP;
      else if (r < ins_w + pop_w + rekey_w) req = REQ_REKEY;
      else req = REQ_UNUSED;
      e = random_entry(crowded);
      // most rekeys aim at a tag that is held
      if (req == REQ_REKEY && held_count > 0 && $urandom_range(0, 4) != 0) begin
        e.tag = held[$urandom_range(0, held_count - 1)].tag;
      end
      send_request(req, e);
      if (req != REQ_UNUSED) counted++;
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 20) begin
      stall_left = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result beat with the oldest expected result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result.status       = out_status;
      seen_result.popped.tag   = out_tag;
      seen_result.popped.prio  = out_prio;
      seen_result.popped.year  = out_year;
      seen_result.popped.month = out_month;
      seen_result.popped.day   = out_day;
      seen_result.next_valid   = out_next_valid;
      seen_result.next_tag     = out_next_tag;
      seen_result.occupancy    = out_occupancy;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_SHOWN) begin
          $display("unexpected result beat: status %0d next_tag %h occupancy %0d",
                   out_status, out_next_tag, out_occupancy);
        end
      end else begin
        wanted_result = pending_results.pop_front();
        n_answered++;
        if (seen_result !== wanted_result) begin
          fault_count++;
          if (fault_count <= MAX_SHOWN) begin
            $display("mismatch on result %0d (expected / actual):", n_answered);
            $display("  status %0d/%0d tag %h/%h prio %0d/%0d date %0d-%0d-%0d / %0d-%0d-%0d",
                     wanted_result.status, seen_result.status,
                     wanted_result.popped.tag, seen_result.popped.tag,
                     wanted_result.popped.prio, seen_result.popped.prio,
                     wanted_result.popped.year, wanted_result.popped.month,
                     wanted_result.popped.day, seen_result.popped.year,
                     seen_result.popped.month, seen_result.popped.day);
            $display("  next_valid %0d/%0d next_tag %h/%h occupancy %0d/%0d",
                     wanted_result.next_valid, seen_result.next_valid,
                     wanted_result.next_tag, seen_result.next_tag,
                     wanted_result.occupancy, seen_result.occupancy);
          end
        end
      end
    end
  end

  // test sequence
  initial begin
    held_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_fill_and_order();
    test_rekey_cases();
    test_pop_head();
    settle_results();

    run_random(400, 40, 35, 20, 1'b0);
    settle_results();
    run_random(200, 70, 10, 16, 1'b0);
    run_random(200, 15, 65, 16, 1'b0);
    settle_results();
    steady = 1'b1;
    run_random(200, 40, 35, 20, 1'b1);
    settle_results();
    steady = 1'b0;
    run_random(300, 45, 30, 21, 1'b1);

    settle_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      fault_count += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("covered %0d requests: %0d inserts, %0d pops, %0d rekeys",
             n_answered, n_inserted, n_popped, n_rekeyed);
    $display("  %0d misses (empty, unknown tag, unused code), %0d full rejects, %0d faults",
             n_missed, n_full, fault_count);
    if (fault_count == 0) begin
      $display("tb_deadline_priority_queue_top: done, clean");
    end else begin
      $display("tb_deadline_priority_queue_top: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/dpq_pkg.sv
src/dpq_datapath.sv
src/dpq_ctrl.sv
src/deadline_priority_queue_top.sv
verif/tb_deadline_priority_queue_top.sv
